>>> sv/mwpg_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the
// multi-waveform PCM generator. No dependencies.
package mwpg_pkg;

  localparam int PHASE_BITS           = 32;
  localparam int SINE_TABLE_ADDR_BITS = 10;
  localparam int AMP_FRAC_BITS        = 15;

  localparam int SINE_DEPTH = (1 << SINE_TABLE_ADDR_BITS) + 1;
  localparam int WAVE_W     = 31;
  localparam int AMP_W      = 16;
  localparam int MAG_W      = WAVE_W + AMP_W;

  localparam logic [WAVE_W-1:0] WAVE_ONE   = 31'h4000_0000;
  localparam logic [63:0]       Q30_ONE    = 64'h4000_0000;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 16'h7FFF;

  typedef enum logic [2:0] {
    SHAPE_SINE   = 3'd0,
    SHAPE_SQUARE = 3'd1,
    SHAPE_SAW    = 3'd2,
    SHAPE_TRI    = 3'd3,
    SHAPE_SILENT = 3'd4
  } shape_e;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S32 = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    REG_SHAPE = 2'd0,
    REG_STEP  = 2'd1,
    REG_AMP   = 2'd2,
    REG_FMT   = 2'd3
  } reg_e;

  typedef struct packed {
    logic [2:0]       shape;
    logic [31:0]      step;
    logic [AMP_W-1:0] amp;
    logic [1:0]       fmt;
  } cfg_t;

  typedef logic [WAVE_W-1:0] sine_rom_t [SINE_DEPTH];

  // sin(k*pi/2/2^ADDR) in Q1.30, degree-13 Taylor series, Horner form
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x  = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      t  = (x * t) >> 30;
      rom[k] = (t > Q30_ONE) ? WAVE_ONE : t[WAVE_W-1:0];
    end
    return rom;
  endfunction

endpackage

>>> sv/mwpg_cfg.sv
// Configuration register file: shape, phase step, amplitude, sample format.
// Depends on mwpg_pkg.
module mwpg_cfg import mwpg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [1:0]  idx_i,
  input  logic [31:0] data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shape <= SHAPE_SINE;
      cfg_q.step  <= '0;
      cfg_q.amp   <= AMP_RESET;
      cfg_q.fmt   <= FMT_S16;
    end else if (we_i) begin
      case (idx_i)
        REG_SHAPE: cfg_q.shape <= data_i[2:0];
        REG_STEP:  cfg_q.step  <= data_i;
        REG_AMP:   cfg_q.amp   <= data_i[AMP_W-1:0];
        REG_FMT:   cfg_q.fmt   <= data_i[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/mwpg_phase.sv
// Stage 1: phase accumulator, restart, quarter-wave sine ROM with registered read.
// Depends on mwpg_pkg.
module mwpg_phase import mwpg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       step_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic              tick_i,
  input  logic              restart_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [31:0]       u_o,
  output logic [WAVE_W-1:0] sine_o
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam logic [SINE_TABLE_ADDR_BITS:0] SINE_N =
    (SINE_TABLE_ADDR_BITS+1)'(1) << SINE_TABLE_ADDR_BITS;

  logic [PHASE_BITS-1:0]         phase_q, phase_d, phase_cur;
  logic [PHASE_BITS+31:0]        phase_wide;
  logic [31:0]                   u, u_q;
  logic [SINE_TABLE_ADDR_BITS-1:0] k;
  logic [SINE_TABLE_ADDR_BITS:0]   addr;
  logic [WAVE_W-1:0]             sine_q;
  logic                          valid_q;
  logic                          acc;

  assign ready_o = !valid_q || ready_i;
  assign acc     = valid_i && ready_o;

  always_comb begin
    phase_cur  = restart_i ? '0 : phase_q;
    phase_wide = {phase_cur, 32'b0} >> PHASE_BITS;
    u          = phase_wide[31:0];
    k          = u[29 -: SINE_TABLE_ADDR_BITS];
    addr       = u[30] ? SINE_N - {1'b0, k} : {1'b0, k};
    phase_d    = phase_q;
    if (acc) begin
      phase_d = tick_i ? phase_cur + PHASE_BITS'(step_i) : phase_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (ready_o) begin
        valid_q <= acc && tick_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && tick_i) begin
      u_q    <= u;
      sine_q <= SINE_ROM[addr];
    end
  end

  assign valid_o = valid_q;
  assign u_o     = u_q;
  assign sine_o  = sine_q;

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && restart_i && !tick_i |=> phase_q == '0)
    else $error("restart without tick left phase nonzero");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc && (tick_i || restart_i)) |=> $stable(phase_q))
    else $error("phase moved without tick or restart");

endmodule

>>> sv/mwpg_wave.sv
// Stage 2: unit waveform magnitude and sign in Q1.30, scaled by amplitude.
// Depends on mwpg_pkg.
module mwpg_wave import mwpg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        shape_i,
  input  logic [AMP_W-1:0]  amp_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [31:0]       u_i,
  input  logic [WAVE_W-1:0] sine_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [MAG_W-1:0]  mag_o,
  output logic              neg_o
);

  logic [WAVE_W-1:0] saw_abs, abs_w;
  logic [31:0]       tri2;
  logic              neg;
  logic [MAG_W-1:0]  mag_q;
  logic              neg_q, valid_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    saw_abs = u_i[31] ? WAVE_W'(32'h8000_0000 - {1'b0, u_i[31:1]}) : u_i[31:1];
    tri2    = {saw_abs, 1'b0};
    abs_w   = '0;
    neg     = 1'b0;
    case (shape_i)
      SHAPE_SINE: begin
        abs_w = sine_i;
        neg   = u_i[31] && (sine_i != '0);
      end
      SHAPE_SQUARE: begin
        abs_w = WAVE_ONE;
        neg   = u_i[31];
      end
      SHAPE_SAW: begin
        abs_w = saw_abs;
        neg   = u_i[31];
      end
      SHAPE_TRI: begin
        neg   = tri2 < {1'b0, WAVE_ONE};
        abs_w = neg ? WAVE_W'({1'b0, WAVE_ONE} - tri2) : WAVE_W'(tri2 - {1'b0, WAVE_ONE});
      end
      default: begin
        abs_w = '0;
        neg   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mag_q <= {{AMP_W{1'b0}}, abs_w} * {{WAVE_W{1'b0}}, amp_i};
      neg_q <= neg;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule

>>> sv/mwpg_quant.sv
// Stage 3: quantize to 8-bit offset, 16-bit or 32-bit signed PCM with saturation,
// and the output register. Depends on mwpg_pkg.
module mwpg_quant import mwpg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       fmt_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [MAG_W-1:0] mag_i,
  input  logic             neg_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [31:0]      pcm_o,
  output logic             clip_o
);

  localparam int SHIFT = 30 + AMP_FRAC_BITS;
  localparam int T_W   = ((SHIFT > MAG_W) ? SHIFT : MAG_W) + 1;
  localparam int P_W   = T_W + 31;
  localparam logic [T_W-1:0] ONE_T = T_W'(1) << SHIFT;

  logic [T_W-1:0] mag_t, m_sel;
  logic [P_W-1:0] m_ext, prod, r, lim;
  logic           over;
  logic [31:0]    pcm_d, pcm_q;
  logic           clip_d, clip_q, valid_q;

  assign ready_o = !valid_q || ready_i;

  // m * (2^k - 1) as a shift and subtract
  always_comb begin
    mag_t  = T_W'(mag_i);
    over   = neg_i && (mag_t > ONE_T);
    m_sel  = mag_t;
    prod   = '0;
    r      = '0;
    lim    = '0;
    pcm_d  = '0;
    clip_d = 1'b0;
    case (fmt_i)
      FMT_U8: begin
        m_sel = over ? mag_t - ONE_T : (neg_i ? ONE_T - mag_t : ONE_T + mag_t);
        m_ext = P_W'(m_sel);
        prod  = (m_ext << 8) - m_ext;
        r     = prod >> (SHIFT + 1);
        if (over) begin
          clip_d = r != '0;
          pcm_d  = '0;
        end else if (r > P_W'(255)) begin
          clip_d = 1'b1;
          pcm_d  = 32'd255;
        end else begin
          pcm_d  = r[31:0];
        end
      end
      FMT_S16, FMT_S32: begin
        m_ext = P_W'(m_sel);
        if (fmt_i == FMT_S16) begin
          prod = (m_ext << 15) - m_ext;
          lim  = P_W'(32767) + P_W'(neg_i);
        end else begin
          prod = (m_ext << 31) - m_ext;
          lim  = P_W'(32'h7FFF_FFFF) + P_W'(neg_i);
        end
        r = prod >> SHIFT;
        if (r > lim) begin
          r      = lim;
          clip_d = 1'b1;
        end
        pcm_d = neg_i ? 32'(0) - r[31:0] : r[31:0];
      end
      default: begin
        m_ext  = '0;
        pcm_d  = '0;
        clip_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pcm_q  <= pcm_d;
      clip_q <= clip_d;
    end
  end

  assign valid_o = valid_q;
  assign pcm_o   = pcm_q;
  assign clip_o  = clip_q;

  a_u8_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && fmt_i == FMT_U8 |=> pcm_q[31:8] == '0)
    else $error("8-bit sample out of range");

  a_bad_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && !(fmt_i == FMT_U8 || fmt_i == FMT_S16 || fmt_i == FMT_S32)
    |=> !clip_q && pcm_q == '0)
    else $error("unknown format gave nonzero sample");

  a_s16_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && fmt_i == FMT_S16 && !neg_i |=> pcm_q[31:15] == '0)
    else $error("positive 16-bit sample above full scale");

endmodule

>>> sv/multi_waveform_pcm_generator.sv
// Top level of the multi-waveform PCM generator: config registers and the
// three-stage sample pipeline. Depends on mwpg_pkg, mwpg_cfg, mwpg_phase,
// mwpg_wave, mwpg_quant.
//
//  port group   dir  content
//  s_axis_*     in   request: tick, restart
//  m_axis_*     out  PCM sample, clip flag in tuser
//  cfg_*        in   register writes, no read-back
//
// One request per cycle while s_axis_tready is high; a sample passes three registered
// stages after its tick request (phase and sine ROM read, shape and amplitude multiply, quantize).
// The sine ROM read is registered in the first stage; each stage ends in a register.
// Reset clears the phase and loads register defaults; no clearing pass.
// A stall on m_axis fills the stages one by one; s_axis_tready drops only
// when all three hold a sample.
module multi_waveform_pcm_generator import mwpg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] tick, [1] restart, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] pcm_sample
  output logic        m_axis_tuser,   // [0] clipped
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t              cfg;
  logic              v1, r1, v2, r2;
  logic [31:0]       u1;
  logic [WAVE_W-1:0] sine1;
  logic [MAG_W-1:0]  mag2;
  logic              neg2;

  mwpg_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  mwpg_phase u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (cfg.step),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .tick_i    (s_axis_tdata[0]),
    .restart_i (s_axis_tdata[1]),
    .valid_o   (v1),
    .ready_i   (r1),
    .u_o       (u1),
    .sine_o    (sine1)
  );

  mwpg_wave u_wave (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shape_i (cfg.shape),
    .amp_i   (cfg.amp),
    .valid_i (v1),
    .ready_o (r1),
    .u_i     (u1),
    .sine_i  (sine1),
    .valid_o (v2),
    .ready_i (r2),
    .mag_o   (mag2),
    .neg_o   (neg2)
  );

  mwpg_quant u_quant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fmt_i   (cfg.fmt),
    .valid_i (v2),
    .ready_o (r2),
    .mag_i   (mag2),
    .neg_i   (neg2),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .pcm_o   (m_axis_tdata),
    .clip_o  (m_axis_tuser)
  );

endmodule

>>> sim/tb_multi_waveform_pcm_generator.sv
// Testbench for multi_waveform_pcm_generator: a fixed-point sample predictor
// in a scoreboard class, stream drivers and phased config sweeps.
// Depends on mwpg_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb_multi_waveform_pcm_generator;
  import mwpg_pkg::*;

  localparam int          LIMIT_CYCLES  = 400000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          PHASE_COUNT   = 24;
  localparam int          PHASE_ITEMS   = 80;
  localparam logic [2:0]  UNKNOWN_SHAPE = 3'd7;
  localparam logic [1:0]  UNKNOWN_FMT   = 2'd3;
  localparam logic [63:0] UNIT_Q30      = 64'd1 << 30;
  localparam logic [63:0] QUARTER_PI2   = 64'd1686629713;
  localparam int          GAIN_SHIFT    = 45;

  typedef struct {
    logic [31:0] pcm;
    logic        clip;
  } pcm_expect_t;

  class pcm_scoreboard;
    logic [2:0]  shape;
    logic [31:0] step;
    logic [15:0] amp;
    logic [1:0]  fmt;
    logic [31:0] phase_acc;
    int          errors;
    pcm_expect_t pending_samples[$];

    function new();
      shape     = SHAPE_SINE;
      step      = '0;
      amp       = 16'h7FFF;
      fmt       = FMT_S16;
      phase_acc = '0;
      errors    = 0;
    endfunction

    function void set_reg(reg_e idx, logic [31:0] data);
      case (idx)
        REG_SHAPE: shape = data[2:0];
        REG_STEP:  step  = data;
        REG_AMP:   amp   = data[15:0];
        REG_FMT:   fmt   = data[1:0];
        default: ;
      endcase
    endfunction

    // quarter-wave sine in Q1.30, Taylor series to degree 13
    function logic [63:0] quarter_sine(int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] dv [6];
      dv = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      x  = (64'(k) * QUARTER_PI2) >> 10;
      x2 = (x * x) >> 30;
      t  = UNIT_Q30;
      for (int i = 0; i < 6; i++)
        t = UNIT_Q30 - ((x2 * t) >> 30) / dv[i];
      t = (x * t) >> 30;
      return (t > UNIT_Q30) ? UNIT_Q30 : t;
    endfunction

    function longint unit_level(logic [31:0] u);
      longint      saw;
      longint      s;
      int unsigned k;
      saw = longint'(u[31:1]);
      if (u[31]) saw = saw - 64'sd2147483648;
      case (shape)
        SHAPE_SINE: begin
          k = u[29:20];
          if (u[30]) k = 1024 - k;
          s = longint'(quarter_sine(k));
          return u[31] ? -s : s;
        end
        SHAPE_SQUARE: return u[31] ? -longint'(UNIT_Q30) : longint'(UNIT_Q30);
        SHAPE_SAW:    return saw;
        SHAPE_TRI:    return 2 * (saw < 0 ? -saw : saw) - longint'(UNIT_Q30);
        default:      return 0;
      endcase
    endfunction

    function void predict_sample(output logic [31:0] pcm, output logic clip);
      longint       w;
      logic         neg;
      logic [63:0]  mag;
      logic [63:0]  one;
      logic [63:0]  lim;
      logic [63:0]  c;
      logic [127:0] r;
      w    = unit_level(phase_acc);
      neg  = w < 0;
      mag  = (neg ? 64'(-w) : 64'(w)) * {48'd0, amp};
      one  = 64'd1 << GAIN_SHIFT;
      pcm  = '0;
      clip = 1'b0;
      case (fmt)
        FMT_U8: begin
          if (neg && mag > one) begin
            r    = (128'(mag - one) * 128'd255) >> (GAIN_SHIFT + 1);
            clip = r != 0;
          end else begin
            r = (128'(neg ? one - mag : one + mag) * 128'd255) >> (GAIN_SHIFT + 1);
            if (r > 255) begin
              r    = 255;
              clip = 1'b1;
            end
            pcm = r[31:0];
          end
        end
        FMT_S16, FMT_S32: begin
          c   = (fmt == FMT_S16) ? 64'd32767 : 64'd2147483647;
          lim = neg ? c + 1 : c;
          r   = (128'(mag) * 128'(c)) >> GAIN_SHIFT;
          if (r > 128'(lim)) begin
            r    = 128'(lim);
            clip = 1'b1;
          end
          pcm = neg ? (32'd0 - r[31:0]) : r[31:0];
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic tick, logic restart);
      pcm_expect_t e;
      if (restart) phase_acc = '0;
      if (!tick) return;
      predict_sample(e.pcm, e.clip);
      pending_samples.push_back(e);
      phase_acc = phase_acc + step;
    endfunction

    function void check_sample(logic [31:0] pcm, logic clip);
      pcm_expect_t e;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample %h clipped %b", $time, pcm, clip);
        errors++;
        return;
      end
      e = pending_samples.pop_front();
      if (pcm !== e.pcm) begin
        $display("%0t: pcm_sample expected %h actual %h", $time, e.pcm, pcm);
        errors++;
      end
      if (clip !== e.clip) begin
        $display("%0t: clipped expected %b actual %b", $time, e.clip, clip);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] tick, [1] restart, zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] pcm_sample
  logic        m_axis_tuser;        // [0] clipped
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  pcm_scoreboard sb;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_start = 1'b0;
  logic        hold_rx = 1'b0;
  int unsigned cycle_count = 0;

  multi_waveform_pcm_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    wait (hold_start);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tdata[0], s_axis_tdata[1]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_sample(m_axis_tdata, m_axis_tuser);
    end
  end

  task automatic send_request(logic tick, logic restart);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, restart, tick};
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic run_ticks(int n, logic first_restart);
    for (int i = 0; i < n; i++)
      send_request(1'b1, first_restart && i == 0);
    end_burst();
  endtask

  // waits first so the last accepted request is already in the queue
  task automatic wait_idle();
    @(posedge clk_i);
    while (sb.pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(logic [2:0] shape, logic [31:0] step, logic [15:0] amp,
                              logic [1:0] fmt);
    wait_idle();
    write_reg(REG_SHAPE, {29'd0, shape});
    write_reg(REG_STEP, step);
    write_reg(REG_AMP, {16'd0, amp});
    write_reg(REG_FMT, {30'd0, fmt});
  endtask

  task automatic random_phase(int idx);
    logic [2:0]  shape;
    logic [31:0] step;
    logic [15:0] amp;
    logic [1:0]  fmt;
    int          pick;
    shape = 3'($urandom_range(0, 9));
    if ($urandom_range(0, 9) > 7) shape = 3'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       step = '0;
      1:       step = 32'hFFFF_FFFF;
      2:       step = $urandom_range(1, 255);
      3:       step = 32'd1 << $urandom_range(20, 31);
      default: step = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       amp = '0;
      1:       amp = 16'hFFFF;
      2:       amp = 16'h8000;
      3:       amp = 16'h7FFF;
      default: amp = 16'($urandom_range(0, 65535));
    endcase
    pick = $urandom_range(0, 8);
    fmt  = (pick == 8) ? UNKNOWN_FMT : 2'(pick % 3);
    apply_config(shape, step, amp, fmt);
    case (idx % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
      default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
    endcase
    if (idx == 0) hold_start = 1'b1;
    for (int i = 0; i < PHASE_ITEMS; i++)
      send_request($urandom_range(0, 99) < 90, $urandom_range(0, 99) < 6);
    end_burst();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, plus requests with no tick
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b1);
    send_request(1'b1, 1'b0);
    end_burst();

    // square above full scale clips both ways
    apply_config(SHAPE_SQUARE, 32'h8000_0000, 16'hFFFF, FMT_S16);
    send_request(1'b1, 1'b0);
    send_request(1'b1, 1'b0);
    send_request(1'b1, 1'b1);
    end_burst();
    // sawtooth at unity gain, 32-bit, all quadrants
    apply_config(SHAPE_SAW, 32'h4000_0000, 16'h8000, FMT_S32);
    run_ticks(4, 1'b0);
    // triangle, zero amplitude, 8-bit, maximum step
    apply_config(SHAPE_TRI, 32'hFFFF_FFFF, 16'h0000, FMT_U8);
    run_ticks(2, 1'b0);
    // unknown shape and unknown format
    apply_config(UNKNOWN_SHAPE, 32'h0000_0001, 16'hFFFF, UNKNOWN_FMT);
    run_ticks(2, 1'b0);
    // sine quadrants, 8-bit clipping at both rails
    apply_config(SHAPE_SINE, 32'h4000_0000, 16'hFFFF, FMT_U8);
    for (int i = 0; i < 4; i++)
      send_request(1'b1, 1'b0);
    run_ticks(1, 1'b1);
    apply_config(SHAPE_TRI, 32'h4000_0000, 16'hFFFF, FMT_S32);
    run_ticks(4, 1'b1);

    for (int p = 0; p < PHASE_COUNT; p++)
      random_phase(p);

    wait_idle();
    if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> multi_waveform_pcm_generator.f
sv/mwpg_pkg.sv
sv/mwpg_cfg.sv
sv/mwpg_phase.sv
sv/mwpg_wave.sv
sv/mwpg_quant.sv
sv/multi_waveform_pcm_generator.sv
sim/tb_multi_waveform_pcm_generator.sv
